[design/bbs_pkg.sv]
// Shared types, constants and helper functions of the binomial broadcast schedule block.
package bbs_pkg;

  // Largest rank count the block serves, and the cap that the 10-bit rank field allows.
  localparam int MAX_RANKS = 1024;
  localparam int N_CAP     = (MAX_RANKS < 1024) ? MAX_RANKS : 1024;

  localparam int RANK_W  = 10;
  localparam int COUNT_W = 11;
  localparam int ELEM_W  = 24;

  // Depth of the command queue between the front and the back.
  localparam int QDEPTH = 2;
  localparam int QPTR_W = 1;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_RANK_COUNT = 2'd0,
    REG_ROOT_RANK  = 2'd1,
    REG_CONTIG     = 2'd2,
    REG_ELEM_COUNT = 2'd3
  } cfg_reg_e;

  // Result action codes.
  typedef enum logic [1:0] {
    ACT_RECV    = 2'd0,
    ACT_SEND    = 2'd1,
    ACT_INVALID = 2'd2
  } action_e;

  // Buffer selection codes.
  typedef enum logic [1:0] {
    BUF_IN_PLACE   = 2'd0,
    BUF_PREV_RECV  = 2'd1,
    BUF_UNPACK_TMP = 2'd2
  } buf_e;

  // Class of a rank, as decided by the front.
  typedef enum logic [1:0] {
    CMD_INVALID = 2'd0,
    CMD_ROOT    = 2'd1,
    CMD_NONROOT = 2'd2
  } cmd_kind_e;

  typedef enum logic [1:0] {
    F_IDLE,
    F_SETUP,
    F_SEARCH,
    F_PUSH
  } front_state_e;

  typedef enum logic [1:0] {
    B_IDLE,
    B_INV,
    B_RECV,
    B_SEND
  } back_state_e;

  // Live configuration seen by the front.
  typedef struct packed {
    logic [COUNT_W-1:0] rank_count;
    logic [RANK_W-1:0]  root_rank;
    logic               contiguous_layout;
    logic [ELEM_W-1:0]  element_count;
  } cfg_t;

  // Work handed from the front to the back for one rank.
  typedef struct packed {
    cmd_kind_e          kind;
    logic [RANK_W-1:0]  recv_partner;
    logic               send_en;
    logic [RANK_W-1:0]  off;
    logic [COUNT_W-1:0] limit;
    logic [RANK_W-1:0]  stride;
    logic [RANK_W-1:0]  root;
    logic [COUNT_W-1:0] n;
    buf_e               buf_recv;
    buf_e               buf_send;
    logic [ELEM_W-1:0]  elems;
  } cmd_t;

  // One result item.
  typedef struct packed {
    action_e           action;
    logic [RANK_W-1:0] partner;
    buf_e              buf_kind;
    logic [ELEM_W-1:0] elems;
    logic              last;
  } res_t;

  // Smallest power of two that is not below n (n at least 1).
  function automatic logic [COUNT_W-1:0] next_pow2(input logic [COUNT_W-1:0] n);
    logic [COUNT_W-1:0] m;
    logic [COUNT_W-1:0] r;
    m = n - COUNT_W'(1);
    r = COUNT_W'(1);
    for (int i = 0; i < COUNT_W - 1; i++) begin
      if (m[i]) begin
        r = COUNT_W'(2) << i;
      end
    end
    return r;
  endfunction

  // (a + b) mod n where both a and b are below n.
  function automatic logic [RANK_W-1:0] mod_add(input logic [COUNT_W-1:0] a,
                                               input logic [COUNT_W-1:0] b,
                                               input logic [COUNT_W-1:0] n);
    logic [COUNT_W:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    if (sum >= {1'b0, n}) begin
      sum = sum - {1'b0, n};
    end
    return sum[RANK_W-1:0];
  endfunction

endpackage

[design/bbs_front.sv]
// Front part: accepts a rank, classifies it and searches its parent window.
module bbs_front import bbs_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [RANK_W-1:0] in_rank_i,
  input  cfg_t              cfg_i,
  output logic              cmd_valid_o,
  output cmd_t              cmd_o,
  input  logic              cmd_ready_i
);

  front_state_e       state_q, state_d;
  logic [RANK_W-1:0]  me_q, me_d;
  logic [RANK_W-1:0]  off_q, off_d;
  logic [RANK_W-1:0]  start_q, start_d;
  logic [RANK_W-1:0]  size_q, size_d;
  logic [RANK_W-1:0]  split_q, split_d;
  logic [COUNT_W-1:0] n_q, n_d;
  cmd_t               cmd_q, cmd_d;

  logic [COUNT_W-1:0] n_eff;
  logic [COUNT_W-1:0] round_sz;
  logic [COUNT_W-1:0] off_full;
  logic [COUNT_W-1:0] stop_full;
  logic [COUNT_W-1:0] limit;
  logic [RANK_W-1:0]  start_nx;
  logic [RANK_W-1:0]  size_nx;
  logic               in_fire;
  logic               rank_bad;
  logic               is_root;
  logic               lone_root;
  logic               search_done;

  // Classification of the latched rank against the configuration.
  always_comb begin
    n_eff = (cfg_i.rank_count > COUNT_W'(N_CAP)) ? COUNT_W'(N_CAP) : cfg_i.rank_count;
    rank_bad  = ({1'b0, me_q} >= n_eff) || ({1'b0, cfg_i.root_rank} >= n_eff);
    is_root   = (me_q == cfg_i.root_rank);
    lone_root = is_root && (n_eff == COUNT_W'(1));
    round_sz  = next_pow2(n_eff);
    if (me_q >= cfg_i.root_rank) begin
      off_full = {1'b0, me_q} - {1'b0, cfg_i.root_rank};
    end else begin
      off_full = {1'b0, me_q} + n_eff - {1'b0, cfg_i.root_rank};
    end
  end

  // One window-halving step per cycle.
  always_comb begin
    search_done = (size_q == '0) || (off_q == split_q);
    start_nx    = (off_q > split_q) ? split_q : start_q;
    size_nx     = size_q >> 1;
    stop_full   = {1'b0, split_q} + {1'b0, size_q};
    limit       = (stop_full > n_q) ? n_q : stop_full;
  end

  assign in_fire = in_valid_i && in_ready_o;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      F_IDLE: begin
        if (in_fire) state_d = F_SETUP;
      end
      F_SETUP: begin
        if (rank_bad) begin
          state_d = F_PUSH;
        end else if (lone_root) begin
          state_d = F_IDLE;
        end else if (is_root) begin
          state_d = F_PUSH;
        end else begin
          state_d = F_SEARCH;
        end
      end
      F_SEARCH: begin
        if (search_done) state_d = F_PUSH;
      end
      F_PUSH: begin
        if (cmd_ready_i) state_d = F_IDLE;
      end
      default: state_d = F_IDLE;
    endcase
  end

  // Datapath and handshake outputs.
  always_comb begin
    me_d        = me_q;
    off_d       = off_q;
    start_d     = start_q;
    size_d      = size_q;
    split_d     = split_q;
    n_d         = n_q;
    cmd_d       = cmd_q;
    in_ready_o  = 1'b0;
    cmd_valid_o = 1'b0;
    unique case (state_q)
      F_IDLE: begin
        // The input is always ready here, so a valid item is taken.
        in_ready_o = 1'b1;
        if (in_valid_i) me_d = in_rank_i;
      end
      F_SETUP: begin
        n_d                = n_eff;
        cmd_d.root         = cfg_i.root_rank;
        cmd_d.n            = n_eff;
        cmd_d.elems        = cfg_i.element_count;
        cmd_d.recv_partner = '0;
        cmd_d.send_en      = 1'b0;
        cmd_d.off          = '0;
        cmd_d.limit        = n_eff;
        cmd_d.stride       = round_sz[COUNT_W-1:1];
        cmd_d.buf_recv     = BUF_IN_PLACE;
        cmd_d.buf_send     = BUF_IN_PLACE;
        if (rank_bad) begin
          cmd_d.kind = CMD_INVALID;
        end else if (is_root) begin
          cmd_d.kind = CMD_ROOT;
        end else begin
          cmd_d.kind = CMD_NONROOT;
          off_d      = off_full[RANK_W-1:0];
          start_d    = '0;
          size_d     = round_sz[COUNT_W-1:1];
          split_d    = round_sz[COUNT_W-1:1];
        end
      end
      F_SEARCH: begin
        if (search_done) begin
          cmd_d.recv_partner = mod_add({1'b0, start_q}, {1'b0, cfg_i.root_rank}, n_q);
          cmd_d.off          = off_q;
          cmd_d.limit        = limit;
          cmd_d.stride       = size_q;
          cmd_d.send_en      = !off_q[0] && (({1'b0, off_q} + COUNT_W'(1)) < limit);
          cmd_d.buf_recv     = cfg_i.contiguous_layout ? BUF_IN_PLACE : BUF_UNPACK_TMP;
          cmd_d.buf_send     = cfg_i.contiguous_layout ? BUF_IN_PLACE : BUF_PREV_RECV;
        end else begin
          start_d = start_nx;
          size_d  = size_nx;
          split_d = start_nx + size_nx;
        end
      end
      F_PUSH: begin
        cmd_valid_o = 1'b1;
      end
      default: ;
    endcase
  end

  assign cmd_o = cmd_q;

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Working registers.
  always_ff @(posedge clk_i) begin
    me_q    <= me_d;
    off_q   <= off_d;
    start_q <= start_d;
    size_q  <= size_d;
    split_q <= split_d;
    n_q     <= n_d;
    cmd_q   <= cmd_d;
  end

endmodule

[design/bbs_fifo.sv]
// Short command queue that decouples the front from the back.
module bbs_fifo import bbs_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_valid_i,
  output logic push_ready_o,
  input  cmd_t push_data_i,
  output logic pop_valid_o,
  input  logic pop_ready_i,
  output cmd_t pop_data_o
);

  cmd_t              mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QPTR_W:0]   count_q, count_d;
  logic              push;
  logic              pop;

  assign push_ready_o = (count_q != (QPTR_W + 1)'(QDEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = mem_q[rd_ptr_q];

  // Pointer and fill-count updates.
  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + QPTR_W'(1) : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + QPTR_W'(1) : rd_ptr_q;
    count_d  = count_q;
    if (push && !pop) begin
      count_d = count_q + (QPTR_W + 1)'(1);
    end else if (pop && !push) begin
      count_d = count_q - (QPTR_W + 1)'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_ptr_q] <= push_data_i;
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= (QPTR_W + 1)'(QDEPTH))
    else $error("Command queue fill count exceeds its depth.");

  a_count_grow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |=> (count_q == $past(count_q) + (QPTR_W + 1)'(1)))
    else $error("Command queue fill count did not follow a push.");
`endif

endmodule

[design/bbs_back.sv]
// Back part: expands one command into receive and send results.
module bbs_back import bbs_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cmd_valid_i,
  output logic cmd_ready_o,
  input  cmd_t cmd_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output res_t out_res_o
);

  back_state_e       state_q, state_d;
  cmd_t              cmd_q, cmd_d;
  logic [RANK_W-1:0] stride_q, stride_d;
  logic              out_valid_q, out_valid_d;
  res_t              res_q, res_d;

  logic [COUNT_W-1:0] child;
  logic               hit;
  logic               out_free;
  logic               advance;
  logic               emit;

  assign out_free = !out_valid_q || out_ready_i;
  assign child    = {1'b0, cmd_q.off} + {1'b0, stride_q};
  assign hit      = child < cmd_q.limit;
  assign advance  = !hit || out_free;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      B_IDLE: begin
        if (cmd_valid_i) begin
          unique case (cmd_i.kind)
            CMD_INVALID: state_d = B_INV;
            CMD_ROOT:    state_d = B_SEND;
            CMD_NONROOT: state_d = B_RECV;
            default:     state_d = B_INV;
          endcase
        end
      end
      B_INV: begin
        if (out_free) state_d = B_IDLE;
      end
      B_RECV: begin
        if (out_free) state_d = cmd_q.send_en ? B_SEND : B_IDLE;
      end
      B_SEND: begin
        if (advance && (stride_q == RANK_W'(1))) state_d = B_IDLE;
      end
      default: state_d = B_IDLE;
    endcase
  end

  // Result formation and queue handshake.
  always_comb begin
    cmd_ready_o = 1'b0;
    emit        = 1'b0;
    cmd_d       = cmd_q;
    stride_d    = stride_q;
    res_d       = res_q;
    unique case (state_q)
      B_IDLE: begin
        // The queue is always popped here, so a valid command is taken.
        cmd_ready_o = 1'b1;
        if (cmd_valid_i) begin
          cmd_d    = cmd_i;
          stride_d = cmd_i.stride;
        end
      end
      B_INV: begin
        emit           = out_free;
        res_d.action   = ACT_INVALID;
        res_d.partner  = '0;
        res_d.buf_kind = BUF_IN_PLACE;
        res_d.elems    = '0;
        res_d.last     = 1'b1;
      end
      B_RECV: begin
        emit           = out_free;
        res_d.action   = ACT_RECV;
        res_d.partner  = cmd_q.recv_partner;
        res_d.buf_kind = cmd_q.buf_recv;
        res_d.elems    = cmd_q.elems;
        res_d.last     = !cmd_q.send_en;
      end
      B_SEND: begin
        // Strides whose child falls outside the window are skipped.
        emit           = hit && out_free;
        res_d.action   = ACT_SEND;
        res_d.partner  = mod_add(child, {1'b0, cmd_q.root}, cmd_q.n);
        res_d.buf_kind = cmd_q.buf_send;
        res_d.elems    = cmd_q.elems;
        res_d.last     = (stride_q == RANK_W'(1));
        if (advance) stride_d = stride_q >> 1;
      end
      default: ;
    endcase
  end

  // Output register valid flag.
  always_comb begin
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o   = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q    <= cmd_d;
    stride_q <= stride_d;
    if (emit) res_q <= res_d;
  end

`ifndef SYNTHESIS
  a_stride_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == B_SEND) |-> (stride_q != '0))
    else $error("Send walk reached a zero stride.");

  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && res_d.last) |=> (state_q == B_IDLE))
    else $error("Back part kept working after the final result of a rank.");
`endif

endmodule

[design/binomial_bcast_schedule.sv]
// Top level of the binomial-tree broadcast schedule generator.
//
//   Channel  Direction  Handshake                    Payload
//   cfg      in         cfg_valid_i / cfg_ready_o    cfg_index_i, cfg_data_i
//   s_axis   in         s_axis_tvalid / tready       tdata: my_rank
//   m_axis   out        m_axis_tvalid / tready       tdata, tuser, tlast
//
// The front accepts a rank in F_IDLE and sets it up in F_SETUP; a non-root
// rank then takes one window-halving step per cycle (up to ten) until the
// search closes, and F_PUSH hands the command to the queue, holding while
// the queue is full; a lone root pushes no command. The back picks up a
// command in B_IDLE, then gives one result or skips one stride per cycle,
// holding a result while the output is stalled. The parent search loop sets
// the front's time, the stride walk the back's. A two-entry command queue
// lets the front search the next rank while the back still emits. Reset is
// asynchronous and active low, and restores the control state and the
// configuration defaults. The configuration port is always ready.
module binomial_bcast_schedule import bbs_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration write channel.
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [23:0] cfg_data_i,
  // Input stream.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // [9:0] my_rank, [15:10] zero
  // Result stream.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,  // [9:0] partner_rank, [33:10] elements_moved, [39:34] zero
  output logic [3:0]  m_axis_tuser,  // [1:0] action_kind, [3:2] buffer_kind
  output logic        m_axis_tlast   // last_result
);

  cfg_t     cfg_q, cfg_d;
  cfg_reg_e cfg_sel;
  logic     cfg_fire;

  logic cmd_push_valid;
  logic cmd_push_ready;
  cmd_t cmd_push;
  logic cmd_pop_valid;
  logic cmd_pop_ready;
  cmd_t cmd_pop;
  res_t res;

  // Configuration registers.
  assign cfg_ready_o = 1'b1;
  assign cfg_fire    = cfg_valid_i && cfg_ready_o;
  assign cfg_sel     = cfg_reg_e'(cfg_index_i);

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_fire) begin
      unique case (cfg_sel)
        REG_RANK_COUNT: cfg_d.rank_count        = cfg_data_i[COUNT_W-1:0];
        REG_ROOT_RANK:  cfg_d.root_rank         = cfg_data_i[RANK_W-1:0];
        REG_CONTIG:     cfg_d.contiguous_layout = cfg_data_i[0];
        REG_ELEM_COUNT: cfg_d.element_count     = cfg_data_i[ELEM_W-1:0];
        default:        ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.rank_count        <= COUNT_W'(1);
      cfg_q.root_rank         <= '0;
      cfg_q.contiguous_layout <= 1'b1;
      cfg_q.element_count     <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Front: classification and parent search.
  bbs_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_rank_i   (s_axis_tdata[RANK_W-1:0]),
    .cfg_i       (cfg_q),
    .cmd_valid_o (cmd_push_valid),
    .cmd_o       (cmd_push),
    .cmd_ready_i (cmd_push_ready)
  );

  // Command queue.
  bbs_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (cmd_push_valid),
    .push_ready_o (cmd_push_ready),
    .push_data_i  (cmd_push),
    .pop_valid_o  (cmd_pop_valid),
    .pop_ready_i  (cmd_pop_ready),
    .pop_data_o   (cmd_pop)
  );

  // Back: result emission.
  bbs_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_pop_valid),
    .cmd_ready_o (cmd_pop_ready),
    .cmd_i       (cmd_pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_res_o   (res)
  );

  // Result packing.
  assign m_axis_tdata = {6'd0, res.elems, res.partner};
  assign m_axis_tuser = {res.buf_kind, res.action};
  assign m_axis_tlast = res.last;

endmodule
